// File: hdl/mmh_pkg.sv
// Shared types, constants and the microcode table of the MurmurHash3 x64_128 filter.
package mmh_pkg;

  // Key length counter width
  localparam int unsigned LEN_BITS = 32;

  // Microprogram counter width
  localparam int unsigned UPC_W = 7;

  // Hash constants
  localparam logic [63:0] MIX_C1    = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MIX_C2    = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] LANE1_ADD = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] LANE2_ADD = 64'h0000_0000_3849_5ab5;
  localparam logic [63:0] FIN_C1    = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FIN_C2    = 64'hc4ce_b9fe_1a85_ec53;

  // Register map (byte address bit that selects the register)
  localparam logic REG_SEED   = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LD_W1,     // t = low block word, masked to the tail length
    OP_LD_W2,     // t = high block word, masked to the tail length
    OP_MUL_LL,    // acc = t.lo * k.lo
    OP_MUL_LH,    // acc += (t.lo * k.hi) << 32
    OP_MUL_HL,    // t = acc + (t.hi * k.lo) << 32
    OP_ROT31,     // t = rotl(t, 31)
    OP_ROT33,     // t = rotl(t, 33)
    OP_XSH33,     // t ^= t >> 33
    OP_H1_XOR_T,
    OP_H2_XOR_T,
    OP_H1_RA,     // h1 = rotl(h1, 27) + h2
    OP_H2_RA,     // h2 = rotl(h2, 31) + h1
    OP_H1_M5,     // h1 = h1 * 5 + LANE1_ADD
    OP_H2_M5,     // h2 = h2 * 5 + LANE2_ADD
    OP_XOR_LEN,   // h1 ^= len, h2 ^= len
    OP_H1_ADD,    // h1 += h2
    OP_H2_ADD,    // h2 += h1
    OP_T_H1,
    OP_T_H2,
    OP_H1_T,
    OP_H2_T
  } uop_t;

  // Multiplier constant select
  typedef enum logic [1:0] {
    K_C1,
    K_C2,
    K_F1,
    K_F2
  } kc_t;

  // Sequencing of the next step
  typedef enum logic [2:0] {
    J_NEXT,   // fall through
    J_GOTO,   // unconditional jump
    J_SHORT,  // jump if the tail has at most eight bytes
    J_LAST,   // jump if the key ended, else end
    J_EMIT,   // wait for the output register, hand off the digest, end
    J_END     // end of program
  } jmp_t;

  typedef struct packed {
    uop_t             op;
    kc_t              kc;
    jmp_t             jmp;
    logic [UPC_W-1:0] tgt;
  } ucw_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic start;     // byte taken that needs a program run
    logic boundary;  // that byte completed a 16-byte block
    logic last;      // current key has ended
    logic rem_gt8;   // tail holds more than eight bytes
  } dp_st_t;

  // Program entry points
  localparam logic [UPC_W-1:0] A_BLOCK = UPC_W'(0);
  localparam logic [UPC_W-1:0] A_TAIL  = UPC_W'(22);
  localparam logic [UPC_W-1:0] A_TAIL1 = UPC_W'(31);
  localparam logic [UPC_W-1:0] A_FINAL = UPC_W'(40);

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned s);
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic ucw_t mk(input uop_t op, input kc_t kc, input jmp_t jmp,
                              input logic [UPC_W-1:0] tgt);
    ucw_t w;
    w.op  = op;
    w.kc  = kc;
    w.jmp = jmp;
    w.tgt = tgt;
    return w;
  endfunction

  // Microprogram
  function automatic ucw_t ucode(input logic [UPC_W-1:0] a);
    ucw_t w;
    w = mk(OP_NOP, K_C1, J_END, A_BLOCK);
    case (a)
      // block: lane one
      0:  w = mk(OP_LD_W1,    K_C1, J_NEXT, A_BLOCK);
      1:  w = mk(OP_MUL_LL,   K_C1, J_NEXT, A_BLOCK);
      2:  w = mk(OP_MUL_LH,   K_C1, J_NEXT, A_BLOCK);
      3:  w = mk(OP_MUL_HL,   K_C1, J_NEXT, A_BLOCK);
      4:  w = mk(OP_ROT31,    K_C1, J_NEXT, A_BLOCK);
      5:  w = mk(OP_MUL_LL,   K_C2, J_NEXT, A_BLOCK);
      6:  w = mk(OP_MUL_LH,   K_C2, J_NEXT, A_BLOCK);
      7:  w = mk(OP_MUL_HL,   K_C2, J_NEXT, A_BLOCK);
      8:  w = mk(OP_H1_XOR_T, K_C1, J_NEXT, A_BLOCK);
      9:  w = mk(OP_H1_RA,    K_C1, J_NEXT, A_BLOCK);
      10: w = mk(OP_H1_M5,    K_C1, J_NEXT, A_BLOCK);
      // block: lane two
      11: w = mk(OP_LD_W2,    K_C1, J_NEXT, A_BLOCK);
      12: w = mk(OP_MUL_LL,   K_C2, J_NEXT, A_BLOCK);
      13: w = mk(OP_MUL_LH,   K_C2, J_NEXT, A_BLOCK);
      14: w = mk(OP_MUL_HL,   K_C2, J_NEXT, A_BLOCK);
      15: w = mk(OP_ROT33,    K_C1, J_NEXT, A_BLOCK);
      16: w = mk(OP_MUL_LL,   K_C1, J_NEXT, A_BLOCK);
      17: w = mk(OP_MUL_LH,   K_C1, J_NEXT, A_BLOCK);
      18: w = mk(OP_MUL_HL,   K_C1, J_NEXT, A_BLOCK);
      19: w = mk(OP_H2_XOR_T, K_C1, J_NEXT, A_BLOCK);
      20: w = mk(OP_H2_RA,    K_C1, J_NEXT, A_BLOCK);
      21: w = mk(OP_H2_M5,    K_C1, J_LAST, A_FINAL);
      // tail: high word
      22: w = mk(OP_LD_W2,    K_C1, J_SHORT, A_TAIL1);
      23: w = mk(OP_MUL_LL,   K_C2, J_NEXT, A_BLOCK);
      24: w = mk(OP_MUL_LH,   K_C2, J_NEXT, A_BLOCK);
      25: w = mk(OP_MUL_HL,   K_C2, J_NEXT, A_BLOCK);
      26: w = mk(OP_ROT33,    K_C1, J_NEXT, A_BLOCK);
      27: w = mk(OP_MUL_LL,   K_C1, J_NEXT, A_BLOCK);
      28: w = mk(OP_MUL_LH,   K_C1, J_NEXT, A_BLOCK);
      29: w = mk(OP_MUL_HL,   K_C1, J_NEXT, A_BLOCK);
      30: w = mk(OP_H2_XOR_T, K_C1, J_NEXT, A_BLOCK);
      // tail: low word
      31: w = mk(OP_LD_W1,    K_C1, J_NEXT, A_BLOCK);
      32: w = mk(OP_MUL_LL,   K_C1, J_NEXT, A_BLOCK);
      33: w = mk(OP_MUL_LH,   K_C1, J_NEXT, A_BLOCK);
      34: w = mk(OP_MUL_HL,   K_C1, J_NEXT, A_BLOCK);
      35: w = mk(OP_ROT31,    K_C1, J_NEXT, A_BLOCK);
      36: w = mk(OP_MUL_LL,   K_C2, J_NEXT, A_BLOCK);
      37: w = mk(OP_MUL_LH,   K_C2, J_NEXT, A_BLOCK);
      38: w = mk(OP_MUL_HL,   K_C2, J_NEXT, A_BLOCK);
      39: w = mk(OP_H1_XOR_T, K_C1, J_NEXT, A_BLOCK);
      // finalization
      40: w = mk(OP_XOR_LEN,  K_C1, J_NEXT, A_BLOCK);
      41: w = mk(OP_H1_ADD,   K_C1, J_NEXT, A_BLOCK);
      42: w = mk(OP_H2_ADD,   K_C1, J_NEXT, A_BLOCK);
      // avalanche lane one
      43: w = mk(OP_T_H1,     K_C1, J_NEXT, A_BLOCK);
      44: w = mk(OP_XSH33,    K_C1, J_NEXT, A_BLOCK);
      45: w = mk(OP_MUL_LL,   K_F1, J_NEXT, A_BLOCK);
      46: w = mk(OP_MUL_LH,   K_F1, J_NEXT, A_BLOCK);
      47: w = mk(OP_MUL_HL,   K_F1, J_NEXT, A_BLOCK);
      48: w = mk(OP_XSH33,    K_C1, J_NEXT, A_BLOCK);
      49: w = mk(OP_MUL_LL,   K_F2, J_NEXT, A_BLOCK);
      50: w = mk(OP_MUL_LH,   K_F2, J_NEXT, A_BLOCK);
      51: w = mk(OP_MUL_HL,   K_F2, J_NEXT, A_BLOCK);
      52: w = mk(OP_XSH33,    K_C1, J_NEXT, A_BLOCK);
      53: w = mk(OP_H1_T,     K_C1, J_NEXT, A_BLOCK);
      // avalanche lane two
      54: w = mk(OP_T_H2,     K_C1, J_NEXT, A_BLOCK);
      55: w = mk(OP_XSH33,    K_C1, J_NEXT, A_BLOCK);
      56: w = mk(OP_MUL_LL,   K_F1, J_NEXT, A_BLOCK);
      57: w = mk(OP_MUL_LH,   K_F1, J_NEXT, A_BLOCK);
      58: w = mk(OP_MUL_HL,   K_F1, J_NEXT, A_BLOCK);
      59: w = mk(OP_XSH33,    K_C1, J_NEXT, A_BLOCK);
      60: w = mk(OP_MUL_LL,   K_F2, J_NEXT, A_BLOCK);
      61: w = mk(OP_MUL_LH,   K_F2, J_NEXT, A_BLOCK);
      62: w = mk(OP_MUL_HL,   K_F2, J_NEXT, A_BLOCK);
      63: w = mk(OP_XSH33,    K_C1, J_NEXT, A_BLOCK);
      64: w = mk(OP_H2_T,     K_C1, J_NEXT, A_BLOCK);
      // closing lane sums and hand-off
      65: w = mk(OP_H1_ADD,   K_C1, J_NEXT, A_BLOCK);
      66: w = mk(OP_H2_ADD,   K_C1, J_NEXT, A_BLOCK);
      67: w = mk(OP_NOP,      K_C1, J_EMIT, A_BLOCK);
      default: w = mk(OP_NOP, K_C1, J_END, A_BLOCK);
    endcase
    return w;
  endfunction

endpackage

// File: hdl/mmh_seq.sv
// Microprogram sequencer: step counter, control word fetch and jump logic.
module mmh_seq
  import mmh_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  dp_st_t st,
  input  logic   out_free,
  output ucw_t   cw,
  output logic   step_en,
  output logic   emit,
  output logic   busy
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             busy_r, busy_nxt;

  // control word fetch
  assign cw   = ucode(upc_r);
  assign busy = busy_r;

  // a hand-off step stalls while the output register is still full
  assign step_en = busy_r && !((cw.jmp == J_EMIT) && !out_free);
  assign emit    = busy_r && (cw.jmp == J_EMIT) && out_free;

  // next step
  always_comb begin
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (st.start) begin
        busy_nxt = 1'b1;
        upc_nxt  = st.boundary ? A_BLOCK : A_TAIL;
      end
    end else begin
      case (cw.jmp)
        J_NEXT:  upc_nxt = upc_r + UPC_W'(1);
        J_GOTO:  upc_nxt = cw.tgt;
        J_SHORT: upc_nxt = st.rem_gt8 ? upc_r + UPC_W'(1) : cw.tgt;
        J_LAST: begin
          if (st.last) begin
            upc_nxt = cw.tgt;
          end else begin
            busy_nxt = 1'b0;
          end
        end
        J_EMIT: begin
          if (out_free) begin
            busy_nxt = 1'b0;
          end
        end
        J_END:   busy_nxt = 1'b0;
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= A_BLOCK;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

endmodule

// File: hdl/mmh_dp.sv
// Hash datapath: lanes, block buffer, byte counter, shared 32x32 multiplier.
module mmh_dp
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  key_byte,
  input  logic        last_byte,
  input  logic [31:0] seed,
  input  ucw_t        cw,
  input  logic        step_en,
  output dp_st_t      st,
  output logic [63:0] h1,
  output logic [63:0] h2
);

  logic [63:0]         h1_r, h1_nxt;
  logic [63:0]         h2_r, h2_nxt;
  logic [63:0]         t_r, t_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [7:0]          buf_r [16];
  logic [LEN_BITS-1:0] count_r, count_nxt;
  logic                in_key_r;
  logic                last_r;
  logic [3:0]          wr_idx;
  logic [3:0]          rem;
  logic [63:0]         w1, w2;
  logic [63:0]         kval;
  logic [31:0]         ma, mb;
  logic [63:0]         prod;
  logic [63:0]         len64;

  // byte intake
  assign count_nxt = in_key_r ? count_r + LEN_BITS'(1) : LEN_BITS'(1);
  assign wr_idx    = in_key_r ? count_r[3:0] : 4'd0;
  assign rem       = count_r[3:0];
  assign len64     = 64'(count_r);

  assign st.start    = take && ((count_nxt[3:0] == 4'd0) || last_byte);
  assign st.boundary = (count_nxt[3:0] == 4'd0);
  assign st.last     = last_r;
  assign st.rem_gt8  = (rem > 4'd8);

  assign h1 = h1_r;
  assign h2 = h2_r;

  // little-endian block words, bytes past the tail masked off
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      w1[8*b +: 8] = ((rem == 4'd0) || (4'(b) < rem)) ? buf_r[b] : 8'h00;
      w2[8*b +: 8] = ((rem == 4'd0) || (4'(b + 8) < rem)) ? buf_r[b + 8] : 8'h00;
    end
  end

  // multiplier operands
  always_comb begin
    case (cw.kc)
      K_C1:    kval = MIX_C1;
      K_C2:    kval = MIX_C2;
      K_F1:    kval = FIN_C1;
      K_F2:    kval = FIN_C2;
      default: kval = MIX_C1;
    endcase
    ma   = (cw.op == OP_MUL_HL) ? t_r[63:32] : t_r[31:0];
    mb   = (cw.op == OP_MUL_LH) ? kval[63:32] : kval[31:0];
    prod = 64'(ma) * 64'(mb);
  end

  // micro-operation execute
  always_comb begin
    h1_nxt  = h1_r;
    h2_nxt  = h2_r;
    t_nxt   = t_r;
    acc_nxt = acc_r;
    if (take && !in_key_r) begin
      h1_nxt = 64'(seed);
      h2_nxt = 64'(seed);
    end
    if (step_en) begin
      case (cw.op)
        OP_NOP:      ;
        OP_LD_W1:    t_nxt = w1;
        OP_LD_W2:    t_nxt = w2;
        OP_MUL_LL:   acc_nxt = prod;
        OP_MUL_LH:   acc_nxt = acc_r + {prod[31:0], 32'h0};
        OP_MUL_HL:   t_nxt = acc_r + {prod[31:0], 32'h0};
        OP_ROT31:    t_nxt = rotl(t_r, 31);
        OP_ROT33:    t_nxt = rotl(t_r, 33);
        OP_XSH33:    t_nxt = t_r ^ (t_r >> 33);
        OP_H1_XOR_T: h1_nxt = h1_r ^ t_r;
        OP_H2_XOR_T: h2_nxt = h2_r ^ t_r;
        OP_H1_RA:    h1_nxt = rotl(h1_r, 27) + h2_r;
        OP_H2_RA:    h2_nxt = rotl(h2_r, 31) + h1_r;
        OP_H1_M5:    h1_nxt = {h1_r[61:0], 2'b00} + h1_r + LANE1_ADD;
        OP_H2_M5:    h2_nxt = {h2_r[61:0], 2'b00} + h2_r + LANE2_ADD;
        OP_XOR_LEN: begin
          h1_nxt = h1_r ^ len64;
          h2_nxt = h2_r ^ len64;
        end
        OP_H1_ADD:   h1_nxt = h1_r + h2_r;
        OP_H2_ADD:   h2_nxt = h2_r + h1_r;
        OP_T_H1:     t_nxt = h1_r;
        OP_T_H2:     t_nxt = h2_r;
        OP_H1_T:     h1_nxt = t_r;
        OP_H2_T:     h2_nxt = t_r;
        default:     ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    h1_r  <= h1_nxt;
    h2_r  <= h2_nxt;
    t_r   <= t_nxt;
    acc_r <= acc_nxt;
    if (take) begin
      buf_r[wr_idx] <= key_byte;
    end
  end

  // key tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      in_key_r <= 1'b0;
      last_r   <= 1'b0;
    end else if (take) begin
      count_r  <= count_nxt;
      in_key_r <= !last_byte;
      last_r   <= last_byte;
    end
  end

endmodule

// File: hdl/murmur3_x64_128_hash_filter_top.sv
// Top level of the MurmurHash3 x64_128 filter: register port, sequencer, datapath, result stage.
//
// Usage: a key streams in on the in_ channel one byte per transaction, in key
// order, with in_last_byte set on its final byte (keys have at least one byte).
// For each key one transaction leaves on the out_ channel: the 128-bit digest
// as out_hash_low / out_hash_high and out_selected, set when out_hash_low is
// below the threshold register. Registers sit on the cfg_ port: seed at byte
// address 0 (taken by both lanes when a key starts), threshold at address 8.
// A byte that neither closes a 16-byte block nor ends its key runs no program and
// leaves in_ready high. A byte that closes a block runs a 22-step block program of
// the microcode sequencer, with in_ready low meanwhile; the shared 32x32 multiplier
// needs three steps for each of the 64-bit multiplies and sets that length. The
// last byte adds a tail program (10 steps for up to eight tail bytes, 18 for more,
// none when it closes a block) and a 28-step finalization before out_valid rises.
// Reset clears the sequencer, the byte count and the result stage; registers
// return to seed 0 and threshold all ones. A stalled receiver holds the result
// stage; a following key streams in meanwhile and its program waits at the
// hand-off step until the stage is free.
module murmur3_x64_128_hash_filter_top
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  // digest output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_low,
  output logic [63:0] out_hash_high,
  output logic        out_selected,
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] seed_r;
  logic [63:0] thresh_r;
  logic        out_valid_r;
  logic [63:0] out_low_r;
  logic [63:0] out_high_r;
  logic        out_sel_r;
  logic        take;
  logic        out_free;
  logic        busy;
  logic        step_en;
  logic        emit;
  ucw_t        cw;
  dp_st_t      st;
  logic [63:0] h1, h2;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[3] == REG_THRESH) ? thresh_r : 64'(seed_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      thresh_r <= '1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[3] == REG_SEED) begin
        seed_r <= cfg_pwdata[31:0];
      end else begin
        thresh_r <= cfg_pwdata;
      end
    end
  end

  // input handshake
  assign in_ready = !busy;
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  mmh_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .out_free (out_free),
    .cw       (cw),
    .step_en  (step_en),
    .emit     (emit),
    .busy     (busy)
  );

  mmh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .key_byte  (in_key_byte),
    .last_byte (in_last_byte),
    .seed      (seed_r),
    .cw        (cw),
    .step_en   (step_en),
    .st        (st),
    .h1        (h1),
    .h2        (h2)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_low_r  <= h1;
      out_high_r <= h2;
      out_sel_r  <= (h1 < thresh_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hash_low  = out_low_r;
  assign out_hash_high = out_high_r;
  assign out_selected  = out_sel_r;

endmodule
